/* design/xild_pkg.sv */
// Package for the 8086 instruction length decoder: decode state, result
// record, prefix and opcode constants and the per-opcode information table.
// No dependencies.
package xild_pkg;

   localparam int XILD_MAX_PREFIXES = 4;
   localparam int XILD_PREFIX_SLOTS = 4;

   localparam logic [7:0] PFX_ES   = 8'h26;
   localparam logic [7:0] PFX_CS   = 8'h2E;
   localparam logic [7:0] PFX_SS   = 8'h36;
   localparam logic [7:0] PFX_DS   = 8'h3E;
   localparam logic [7:0] PFX_LOCK = 8'hF0;
   localparam logic [7:0] PFX_REPN = 8'hF2;
   localparam logic [7:0] PFX_REP  = 8'hF3;

   localparam logic [7:0] OP_GRP3_B = 8'hF6;
   localparam logic [7:0] OP_GRP3_W = 8'hF7;

   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP16  = 2'd2;
   localparam logic [1:0] MOD_REG     = 2'd3;
   localparam logic [2:0] RM_DIRECT   = 3'd6;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_MODRM,
      PH_DISP,
      PH_IMM
   } phase_type;

   typedef struct packed {
      phase_type                               phase;
      logic [XILD_PREFIX_SLOTS-1:0][7:0]       prefix_store;
      logic [2:0]                              prefix_total;
      logic [7:0]                              opcode;
      logic [7:0]                              modrm;
      logic                                    modrm_present;
      logic [1:0]                              disp_wanted;
      logic                                    disp_seen;
      logic [15:0]                             displacement;
      logic [2:0]                              imm_wanted;
      logic [1:0]                              imm_seen;
      logic [31:0]                             immediate;
   } state_type;

   typedef struct packed {
      logic [7:0]  opcode_byte;
      logic [31:0] prefix_bytes;
      logic [2:0]  prefix_count;
      logic        modrm_used;
      logic [7:0]  modrm_byte;
      logic [15:0] displacement;
      logic [1:0]  displacement_bytes;
      logic [31:0] immediate;
      logic [2:0]  immediate_bytes;
      logic [3:0]  total_length;
      logic        too_many_prefixes;
   } rsp_type;

   // bit 3: ModR/M follows, bits 2..0: immediate bytes
   localparam logic [3:0] OP_INFO [0:255] = '{
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1,
      4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1,
      4'h9, 4'hA, 4'h9, 4'h9, 4'h8, 4'h8, 4'h8, 4'h8,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h4, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h2, 4'h2, 4'h2, 4'h2, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h1, 4'h2, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1,
      4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2,
      4'h0, 4'h0, 4'h2, 4'h0, 4'h8, 4'h8, 4'h9, 4'hA,
      4'h0, 4'h0, 4'h2, 4'h0, 4'h0, 4'h1, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h1, 4'h1, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'h8,
      4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1,
      4'h2, 4'h2, 4'h4, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h8, 4'h8,
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h8, 4'h8
   };

   function automatic logic is_prefix(input logic [7:0] b);
      return (b == PFX_ES) || (b == PFX_CS) || (b == PFX_SS) || (b == PFX_DS) ||
             (b == PFX_LOCK) || (b == PFX_REPN) || (b == PFX_REP);
   endfunction

endpackage

/* design/xild_ifs.sv */
// Channel interfaces of the instruction length decoder: byte request and
// decoded instruction response, valid/ready handshake. No dependencies.
interface xild_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] instruction_byte;

   modport source (output valid, output instruction_byte, input ready);
   modport sink (input valid, input instruction_byte, output ready);
endinterface

interface xild_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode_byte;
   logic [31:0] prefix_bytes;
   logic [2:0]  prefix_count;
   logic        modrm_used;
   logic [7:0]  modrm_byte;
   logic [15:0] displacement;
   logic [1:0]  displacement_bytes;
   logic [31:0] immediate;
   logic [2:0]  immediate_bytes;
   logic [3:0]  total_length;
   logic        too_many_prefixes;

   modport source (
      output valid, input ready,
      output opcode_byte, output prefix_bytes, output prefix_count,
      output modrm_used, output modrm_byte, output displacement,
      output displacement_bytes, output immediate, output immediate_bytes,
      output total_length, output too_many_prefixes
   );
   modport sink (
      input valid, output ready,
      input opcode_byte, input prefix_bytes, input prefix_count,
      input modrm_used, input modrm_byte, input displacement,
      input displacement_bytes, input immediate, input immediate_bytes,
      input total_length, input too_many_prefixes
   );
endinterface

/* design/xild_step.sv */
// Combinational decode step: current state and one byte give next state and,
// when the byte ends an instruction, the result record. Uses xild_pkg.
module xild_step
   import xild_pkg::*;
#(
   parameter int MAX_PREFIXES = XILD_MAX_PREFIXES
) (
   input  state_type  state,
   input  logic [7:0] byte_in,
   output state_type  state_next,
   output logic       emit,
   output rsp_type    result
);

   logic [3:0] info;
   logic [1:0] modrm_mod;
   logic [2:0] modrm_reg;
   logic [2:0] modrm_rm;
   logic [1:0] disp_count;
   logic [2:0] imm_count;
   logic       err;
   state_type  work;

   assign info      = OP_INFO[state.phase == PH_LEAD ? byte_in : state.opcode];
   assign modrm_mod = byte_in[7:6];
   assign modrm_reg = byte_in[5:3];
   assign modrm_rm  = byte_in[2:0];
   assign disp_count = {1'b0, state.disp_seen} + 2'd1;
   assign imm_count  = {1'b0, state.imm_seen} + 3'd1;

   always_comb begin
      work = state;
      emit = 1'b0;
      err  = 1'b0;
      case (state.phase)
         PH_LEAD: begin
            if (is_prefix(byte_in)) begin
               if (state.prefix_total >= 3'(MAX_PREFIXES)) begin
                  emit = 1'b1;
                  err  = 1'b1;
               end else begin
                  work.prefix_store[state.prefix_total[1:0]] = byte_in;
                  work.prefix_total = state.prefix_total + 3'd1;
               end
            end else begin
               work.opcode = byte_in;
               if (info[3]) begin
                  work.phase = PH_MODRM;
               end else begin
                  work.imm_wanted = info[2:0];
                  if (info[2:0] != 3'd0) work.phase = PH_IMM;
                  else emit = 1'b1;
               end
            end
         end
         PH_MODRM: begin
            work.modrm = byte_in;
            work.modrm_present = 1'b1;
            case (modrm_mod)
               MOD_NO_DISP: work.disp_wanted = (modrm_rm == RM_DIRECT) ? 2'd2 : 2'd0;
               MOD_DISP8:   work.disp_wanted = 2'd1;
               MOD_DISP16:  work.disp_wanted = 2'd2;
               default:     work.disp_wanted = 2'd0;
            endcase
            if (state.opcode == OP_GRP3_B)
               work.imm_wanted = (modrm_reg == 3'd0) ? 3'd1 : 3'd0;
            else if (state.opcode == OP_GRP3_W)
               work.imm_wanted = (modrm_reg == 3'd0) ? 3'd2 : 3'd0;
            else
               work.imm_wanted = info[2:0];
            if (work.disp_wanted != 2'd0) work.phase = PH_DISP;
            else if (work.imm_wanted != 3'd0) work.phase = PH_IMM;
            else emit = 1'b1;
         end
         PH_DISP: begin
            if (state.disp_seen) work.displacement[15:8] = state.displacement[15:8] | byte_in;
            else work.displacement[7:0] = state.displacement[7:0] | byte_in;
            work.disp_seen = disp_count[0];
            if (disp_count >= state.disp_wanted) begin
               if (state.imm_wanted != 3'd0) work.phase = PH_IMM;
               else emit = 1'b1;
            end
         end
         default: begin
            work.immediate[{state.imm_seen, 3'b000} +: 8] =
               state.immediate[{state.imm_seen, 3'b000} +: 8] | byte_in;
            work.imm_seen = imm_count[1:0];
            if (imm_count >= state.imm_wanted) emit = 1'b1;
         end
      endcase
   end

   always_comb begin
      result.prefix_bytes       = work.prefix_store;
      result.prefix_count       = work.prefix_total;
      result.too_many_prefixes  = err;
      result.opcode_byte        = err ? 8'd0 : work.opcode;
      result.modrm_used         = err ? 1'b0 : work.modrm_present;
      result.modrm_byte         = err ? 8'd0 : work.modrm;
      result.displacement       = err ? 16'd0 : work.displacement;
      result.displacement_bytes = err ? 2'd0 : work.disp_wanted;
      result.immediate          = err ? 32'd0 : work.immediate;
      result.immediate_bytes    = err ? 3'd0 : work.imm_wanted;
      result.total_length       = err ? 4'd0 :
         {1'b0, work.prefix_total} + 4'd1 + {3'b000, work.modrm_present} +
         {2'b00, work.disp_wanted} + {1'b0, work.imm_wanted};
   end

   assign state_next = emit ? state_type'('0) : work;

endmodule

/* design/x86_16_instruction_length_decoder_unit.sv */
// Top level of the 8086 instruction length decoder: input register, decode
// step, result register. Uses xild_pkg, xild_ifs and xild_step.
//
//   channel   dir  payload                       handshake
//   req_bus   in   instruction_byte              valid/ready
//   rsp_bus   out  decoded instruction record    valid/ready
//
// One byte per cycle while the response is not stalled. Accepted bytes are held
// in the input register; each result is registered before it is offered.
// The decode state advances in one pass of xild_step per byte.
// Reset clears the decode state and both valid flags.
// A stalled response holds the decode stage; one further byte waits in the
// input register, then req_bus.ready drops.
module x86_16_instruction_length_decoder_unit
   import xild_pkg::*;
#(
   parameter int MAX_PREFIXES = XILD_MAX_PREFIXES
) (
   input  logic       clock,
   input  logic       reset,
   xild_req_if.sink   req_bus,
   xild_rsp_if.source rsp_bus
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   state_type  state_ff;
   state_type  state_next;
   logic       out_valid_ff;
   logic       out_valid_in;
   rsp_type    out_ff;
   rsp_type    result;
   logic       emit;
   logic       advance;

   xild_step #(.MAX_PREFIXES(MAX_PREFIXES)) u_step (
      .state      (state_ff),
      .byte_in    (in_byte_ff),
      .state_next (state_next),
      .emit       (emit),
      .result     (result)
   );

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign in_valid_in   = (req_bus.valid && req_bus.ready) || (in_valid_ff && !advance);
   assign out_valid_in  = (advance && emit) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) in_byte_ff <= req_bus.instruction_byte;
      if (advance && emit) out_ff <= result;
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.opcode_byte        = out_ff.opcode_byte;
   assign rsp_bus.prefix_bytes       = out_ff.prefix_bytes;
   assign rsp_bus.prefix_count       = out_ff.prefix_count;
   assign rsp_bus.modrm_used         = out_ff.modrm_used;
   assign rsp_bus.modrm_byte         = out_ff.modrm_byte;
   assign rsp_bus.displacement       = out_ff.displacement;
   assign rsp_bus.displacement_bytes = out_ff.displacement_bytes;
   assign rsp_bus.immediate          = out_ff.immediate;
   assign rsp_bus.immediate_bytes    = out_ff.immediate_bytes;
   assign rsp_bus.total_length       = out_ff.total_length;
   assign rsp_bus.too_many_prefixes  = out_ff.too_many_prefixes;

endmodule

/* design/xild_checker.sv */
// Port-level checks for the instruction length decoder, bound to the top
// level. Uses xild_pkg types only through the top level's ports.
module xild_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  opcode_byte,
   input logic [2:0]  prefix_count,
   input logic        modrm_used,
   input logic [7:0]  modrm_byte,
   input logic [1:0]  displacement_bytes,
   input logic [2:0]  immediate_bytes,
   input logic [3:0]  total_length,
   input logic        too_many_prefixes
);

   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && too_many_prefixes |-> total_length == 4'd0 && opcode_byte == 8'd0 &&
         !modrm_used && displacement_bytes == 2'd0 && immediate_bytes == 3'd0)
      else $error("overflow item carries instruction fields");

   a_length_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !too_many_prefixes |-> total_length ==
         {1'b0, prefix_count} + 4'd1 + {3'b000, modrm_used} +
         {2'b00, displacement_bytes} + {1'b0, immediate_bytes})
      else $error("total length does not match its parts");

   a_no_modrm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !modrm_used |-> modrm_byte == 8'd0 && displacement_bytes == 2'd0)
      else $error("displacement without ModR/M");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(total_length) &&
         $stable(opcode_byte))
      else $error("stalled item changed");

endmodule

bind x86_16_instruction_length_decoder_unit xild_checker u_xild_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .opcode_byte        (rsp_bus.opcode_byte),
   .prefix_count       (rsp_bus.prefix_count),
   .modrm_used         (rsp_bus.modrm_used),
   .modrm_byte         (rsp_bus.modrm_byte),
   .displacement_bytes (rsp_bus.displacement_bytes),
   .immediate_bytes    (rsp_bus.immediate_bytes),
   .total_length       (rsp_bus.total_length),
   .too_many_prefixes  (rsp_bus.too_many_prefixes)
);

/* dv/testbench.sv */
// Self-checking testbench for x86_16_instruction_length_decoder_unit: feeds a byte stream,
// predicts each decoded instruction and checks every result record field by field.
// Depends on xild_pkg, xild_ifs and the decoder top level.
`timescale 1ns / 1ps

module testbench
   import xild_pkg::*;
();

   localparam int DIR_N = 27;
   localparam logic [7:0] SEG_REP [7] = '{PFX_ES, PFX_CS, PFX_SS, PFX_DS,
                                          PFX_LOCK, PFX_REPN, PFX_REP};

   logic clock;
   logic reset;

   xild_req_if req_bus ();
   xild_rsp_if rsp_bus ();

   x86_16_instruction_length_decoder_unit #(
      .MAX_PREFIXES(XILD_MAX_PREFIXES)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // decoder shadow state
   phase_type   st_phase;
   logic [7:0]  st_pfx [4];
   logic [2:0]  st_npfx;
   logic [7:0]  st_op;
   logic [7:0]  st_modrm;
   logic        st_mp;
   logic [1:0]  st_dw;
   int          st_ds;
   logic [15:0] st_disp;
   logic [2:0]  st_iw;
   int          st_is;
   logic [31:0] st_imm;

   rsp_type decoded_q [$];
   rsp_type known_instr [int];
   logic [7:0] dir_bytes [DIR_N] = '{
      8'h90,
      8'hF3, 8'hF2, 8'hF0, 8'h3E, 8'h26,
      8'h2E, 8'h36, 8'hF2, 8'h26, 8'h81, 8'h80, 8'h34, 8'h12, 8'hFF, 8'h7F,
      8'h9A, 8'h11, 8'h22, 8'h33, 8'h44,
      8'hF6, 8'hC0, 8'hFF,
      8'h8B, 8'h46, 8'h80
   };

   int  errors = 0;
   int  bytes_fed = 0;
   int  instr_checked = 0;
   int  overflows = 0;
   int  input_stalls = 0;
   int  hold_left = 0;
   int  squeeze_req = 0;
   int  squeeze_seen = 0;
   bit  calm = 0;
   bit  planned = 0;
   int  pfx_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit is_seg_rep(input logic [7:0] b);
      foreach (SEG_REP[i])
         if (b == SEG_REP[i]) return 1'b1;
      return 1'b0;
   endfunction

   // bit 3: ModR/M follows, bits 2..0: immediate bytes
   function automatic logic [3:0] opcode_shape(input logic [7:0] op);
      if (op < 8'h40) begin
         case (op[2:0])
            3'd4: return 4'h1;
            3'd5: return 4'h2;
            3'd6, 3'd7: return 4'h0;
            default: return 4'h8;
         endcase
      end
      if (op < 8'h70) return 4'h0;
      if (op < 8'h80) return 4'h1;
      if (op < 8'h90) begin
         case (op)
            8'h80, 8'h82, 8'h83: return 4'h9;
            8'h81: return 4'hA;
            default: return 4'h8;
         endcase
      end
      if ((op >= 8'hB0 && op <= 8'hB7) || (op >= 8'hE0 && op <= 8'hE7)) return 4'h1;
      if (op >= 8'hB8 && op <= 8'hBF) return 4'h2;
      if (op >= 8'hD8 && op <= 8'hDF) return 4'h8;
      case (op)
         8'h9A, 8'hEA: return 4'h4;
         8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA9, 8'hC2, 8'hCA, 8'hE8, 8'hE9: return 4'h2;
         8'hA8, 8'hCD, 8'hD4, 8'hD5, 8'hEB: return 4'h1;
         8'hC4, 8'hC5, 8'hD0, 8'hD1, 8'hD2, 8'hD3: return 4'h8;
         8'hF6, 8'hF7, 8'hFE, 8'hFF: return 4'h8;
         8'hC6: return 4'h9;
         8'hC7: return 4'hA;
         default: return 4'h0;
      endcase
   endfunction

   function automatic rsp_type mk_instr(
      input logic [7:0] op, input logic [31:0] pfx, input logic [2:0] npfx,
      input logic hm, input logic [7:0] modrm, input logic [15:0] disp,
      input logic [1:0] db, input logic [31:0] imm, input logic [2:0] ib,
      input logic [3:0] len, input logic err);
      rsp_type r;
      r.opcode_byte        = op;
      r.prefix_bytes       = pfx;
      r.prefix_count       = npfx;
      r.modrm_used         = hm;
      r.modrm_byte         = modrm;
      r.displacement       = disp;
      r.displacement_bytes = db;
      r.immediate          = imm;
      r.immediate_bytes    = ib;
      r.total_length       = len;
      r.too_many_prefixes  = err;
      return r;
   endfunction

   task automatic clear_shadow();
      st_phase = PH_LEAD;
      foreach (st_pfx[i]) st_pfx[i] = 8'h00;
      st_npfx  = '0;
      st_op    = '0;
      st_modrm = '0;
      st_mp    = 1'b0;
      st_dw    = '0;
      st_ds    = 0;
      st_disp  = '0;
      st_iw    = '0;
      st_is    = 0;
      st_imm   = '0;
   endtask

   task automatic close_instr(input bit overflow, output rsp_type r);
      int len;
      r = '0;
      for (int i = 0; i < 4; i++)
         if (i < int'(st_npfx)) r.prefix_bytes[8*i +: 8] = st_pfx[i];
      r.prefix_count = st_npfx;
      if (overflow) begin
         r.too_many_prefixes = 1'b1;
      end else begin
         len = int'(st_npfx) + 1 + int'(st_mp) + int'(st_dw) + int'(st_iw);
         r.opcode_byte        = st_op;
         r.modrm_used         = st_mp;
         r.modrm_byte         = st_modrm;
         r.displacement       = st_disp;
         r.displacement_bytes = st_dw;
         r.immediate          = st_imm;
         r.immediate_bytes    = st_iw;
         r.total_length       = len[3:0];
      end
      clear_shadow();
   endtask

   task automatic imm_or_close(output bit done, output rsp_type r);
      r = '0;
      done = 1'b0;
      if (st_iw != 3'd0) begin
         st_phase = PH_IMM;
      end else begin
         close_instr(1'b0, r);
         done = 1'b1;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, output bit done, output rsp_type r);
      logic [3:0] shape;
      done = 1'b0;
      r = '0;
      case (st_phase)
         PH_LEAD: begin
            if (is_seg_rep(b)) begin
               if (st_npfx >= 3'(XILD_MAX_PREFIXES)) begin
                  close_instr(1'b1, r);
                  done = 1'b1;
               end else begin
                  st_pfx[st_npfx[1:0]] = b;
                  st_npfx++;
               end
            end else begin
               st_op = b;
               shape = opcode_shape(b);
               if (shape[3]) begin
                  st_phase = PH_MODRM;
               end else begin
                  st_iw = shape[2:0];
                  imm_or_close(done, r);
               end
            end
         end
         PH_MODRM: begin
            st_modrm = b;
            st_mp = 1'b1;
            case (b[7:6])
               MOD_NO_DISP: st_dw = (b[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
               MOD_DISP8:   st_dw = 2'd1;
               MOD_DISP16:  st_dw = 2'd2;
               default:     st_dw = 2'd0;
            endcase
            shape = opcode_shape(st_op);
            if (st_op == OP_GRP3_B)      st_iw = (b[5:3] == 3'd0) ? 3'd1 : 3'd0;
            else if (st_op == OP_GRP3_W) st_iw = (b[5:3] == 3'd0) ? 3'd2 : 3'd0;
            else                         st_iw = shape[2:0];
            if (st_dw != 2'd0) st_phase = PH_DISP;
            else imm_or_close(done, r);
         end
         PH_DISP: begin
            st_disp[8*st_ds +: 8] = b;
            st_ds++;
            if (st_ds >= int'(st_dw)) imm_or_close(done, r);
         end
         default: begin
            st_imm[8*st_is +: 8] = b;
            st_is++;
            if (st_is >= int'(st_iw)) begin
               close_instr(1'b0, r);
               done = 1'b1;
            end
         end
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit known, input rsp_type known_r);
      bit done;
      rsp_type r;
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.instruction_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      bytes_fed++;
      decode_byte(b, done, r);
      if (known) r = known_r;
      if (done || known) begin
         decoded_q.push_back(r);
         if (r.too_many_prefixes) overflows++;
      end
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         req_bus.instruction_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly well-formed instructions with random content, some noise bytes
   task automatic next_stream_byte(output logic [7:0] b);
      int r;
      logic [3:0] shape;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 8) return;
      case (st_phase)
         PH_LEAD: begin
            if (!planned) begin
               r = $urandom_range(0, 99);
               pfx_left = (r < 50) ? 0 : (r < 93) ? $urandom_range(1, 4) : 5;
               planned = 1'b1;
            end
            if (pfx_left > 0) begin
               pfx_left--;
               b = SEG_REP[$urandom_range(0, 6)];
            end else begin
               planned = 1'b0;
               r = $urandom_range(0, 99);
               if (r < 20) begin
                  b = $urandom_range(0, 1) ? OP_GRP3_W : OP_GRP3_B;
               end else begin
                  b = 8'($urandom_range(0, 255));
                  shape = opcode_shape(b);
                  while (is_seg_rep(b) || (r < 55 && !shape[3])) begin
                     b = 8'($urandom_range(0, 255));
                     shape = opcode_shape(b);
                  end
               end
            end
         end
         PH_MODRM: begin
            if ($urandom_range(0, 3) == 0) b[5:3] = 3'd0;
            if ($urandom_range(0, 4) == 0) begin
               b[7:6] = MOD_NO_DISP;
               b[2:0] = RM_DIRECT;
            end
         end
         default: ;
      endcase
   endtask

   task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (decoded_q.size() == 0) begin
         $error("unexpected result: opcode_byte %h", rsp_bus.opcode_byte);
         errors++;
         return;
      end
      want = decoded_q.pop_front();
      instr_checked++;
      cmp_field("opcode_byte", 32'(want.opcode_byte), 32'(rsp_bus.opcode_byte));
      cmp_field("prefix_bytes", want.prefix_bytes, rsp_bus.prefix_bytes);
      cmp_field("prefix_count", 32'(want.prefix_count), 32'(rsp_bus.prefix_count));
      cmp_field("modrm_used", 32'(want.modrm_used), 32'(rsp_bus.modrm_used));
      cmp_field("modrm_byte", 32'(want.modrm_byte), 32'(rsp_bus.modrm_byte));
      cmp_field("displacement", 32'(want.displacement), 32'(rsp_bus.displacement));
      cmp_field("displacement_bytes", 32'(want.displacement_bytes),
                32'(rsp_bus.displacement_bytes));
      cmp_field("immediate", want.immediate, rsp_bus.immediate);
      cmp_field("immediate_bytes", 32'(want.immediate_bytes), 32'(rsp_bus.immediate_bytes));
      cmp_field("total_length", 32'(want.total_length), 32'(rsp_bus.total_length));
      cmp_field("too_many_prefixes", 32'(want.too_many_prefixes),
                32'(rsp_bus.too_many_prefixes));
   endtask

   // result side: checks and random back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_bus.valid && rsp_bus.ready) check_result();
            if (req_bus.valid && !req_bus.ready) input_stalls++;
            if (squeeze_seen != squeeze_req) begin
               squeeze_seen = squeeze_req;
               hold_left = 120;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_bus.ready <= 1'b0;
            end else if (calm || $urandom_range(0, 9) < 7) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               hold_left = pick_gap();
            end
         end
      end
   end

   initial begin
      logic [7:0] b;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.instruction_byte <= 8'h00;
      clear_shadow();
      known_instr[0]  = mk_instr(8'h90, 32'h0, 3'd0, 1'b0, 8'h00, 16'h0, 2'd0,
                                 32'h0, 3'd0, 4'd1, 1'b0);
      known_instr[5]  = mk_instr(8'h00, 32'h3EF0F2F3, 3'd4, 1'b0, 8'h00, 16'h0, 2'd0,
                                 32'h0, 3'd0, 4'd0, 1'b1);
      known_instr[15] = mk_instr(8'h81, 32'h26F2362E, 3'd4, 1'b1, 8'h80, 16'h1234, 2'd2,
                                 32'h7FFF, 3'd2, 4'd10, 1'b0);
      known_instr[20] = mk_instr(8'h9A, 32'h0, 3'd0, 1'b0, 8'h00, 16'h0, 2'd0,
                                 32'h44332211, 3'd4, 4'd5, 1'b0);
      known_instr[23] = mk_instr(8'hF6, 32'h0, 3'd0, 1'b1, 8'hC0, 16'h0, 2'd0,
                                 32'hFF, 3'd1, 4'd3, 1'b0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++)
         send_byte(dir_bytes[i], known_instr.exists(i),
                   known_instr.exists(i) ? known_instr[i] : rsp_type'(0));

      for (int n = 0; n < 800; n++) begin
         calm = (n >= 300 && n < 450) || (n >= 600 && n < 650);
         if (n == 300 || n == 620) squeeze_req++;
         next_stream_byte(b);
         send_byte(b, 1'b0, rsp_type'(0));
      end
      req_bus.valid <= 1'b0;
      calm = 1'b0;

      while (decoded_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d bytes fed, %0d instructions checked (%0d prefix overflows)",
               bytes_fed, instr_checked, overflows);
      $display("input held off on %0d cycles by result back-pressure", input_stalls);
      if (errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

endmodule
